// File: hw/rtl/route_table_lpm_engine_top_assert.svh
// ----------------------------------------------------------------------------
// route table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_LPM_ENGINE_TOP_ASSERT_SVH
`define ROUTE_TABLE_LPM_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RTLE_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtle check failed");

// next-cycle implication, checked out of reset
`define RTLE_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtle check failed");

`endif

// File: hw/rtl/rtle_pkg.sv
// ----------------------------------------------------------------------------
// rtle_pkg
// shared types and constants of the route table lpm engine
// ----------------------------------------------------------------------------
package rtle_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int K_W             = 6;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_LOOKUP  = 3'd1;
    localparam logic [2:0] CMD_DEL_IDX = 3'd2;
    localparam logic [2:0] CMD_DEL_PI  = 3'd3;
    localparam logic [2:0] CMD_DEL_RT  = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;
    localparam logic [2:0] CMD_LIST    = 3'd6;
    localparam logic [2:0] CMD_UNUSED  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] PROTO_CONN = 3'd0;
    localparam logic [2:0] PROTO_RIP  = 3'd2;

    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [7:0]  distance;
        logic [15:0] metric;
        logic [31:0] next_hop;
        logic [2:0]  protocol;
        logic [3:0]  iface;
    } t_entry;

    typedef struct packed {
        logic        found;
        logic [5:0]  index;
        t_entry      ent;
        logic [1:0]  status;
        logic        rr;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_msg;

endpackage

// File: hw/rtl/rtle_ram.sv
// ----------------------------------------------------------------------------
// rtle_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rtle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rtle_core.sv
// ----------------------------------------------------------------------------
// rtle_core
// command sequencer: scans the table ram, compacts in place, builds results
// ----------------------------------------------------------------------------
module rtle_core #(
    parameter int TABLE_DEPTH = rtle_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_cmd,
    input  rtle_pkg::t_entry         i_req,
    input  logic [5:0]               i_entry_index,
    input  logic [31:0]              i_dest_addr,
    input  logic                     i_free,
    output rtle_pkg::t_res_msg       o_msg,
    output logic                     o_ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_waddr,
    output rtle_pkg::t_entry         o_ram_wdata,
    output logic                     o_ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_raddr,
    input  rtle_pkg::t_entry         i_ram_rdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [rtle_pkg::K_W-1:0] KMAX = rtle_pkg::K_W'(rtle_pkg::MAX_RESULTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [2:0]                  r_cmd, n_cmd;
    rtle_pkg::t_entry            r_req, n_req;
    logic [5:0]                  r_idx, n_idx;
    logic [31:0]                 r_dest, n_dest;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_rd, n_rd;
    logic [CW-1:0]               r_w, n_w;
    logic                        r_dv, n_dv;
    logic [IW-1:0]               r_di, n_di;
    logic                        r_hit, n_hit;
    logic [5:0]                  r_best, n_best;
    rtle_pkg::t_result           r_res, n_res;
    rtle_pkg::t_result           r_pend, n_pend;
    logic                        r_pend_v, n_pend_v;
    logic [rtle_pkg::K_W-1:0]    r_k, n_k;

    rtle_pkg::t_entry  e;
    rtle_pkg::t_result res_none;
    rtle_pkg::t_result res_ent;
    logic [31:0]       mask;
    logic              same_route, lpm_hit, list_hit, del_hit, keep;
    logic              list_new, stall, emit;
    logic [5:0]        pfx_sat;

    always_comb begin
        res_none = '0;
        res_none.status = rtle_pkg::ST_OK;
        res_none.last = 1'b1;
    end

    assign e = i_ram_rdata;
    assign pfx_sat = (i_req.prefix > 6'd32) ? 6'd32 : i_req.prefix;
    assign mask = (e.prefix == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - e.prefix));

    always_comb begin
        res_ent = '0;
        res_ent.found = 1'b1;
        res_ent.index = 6'(r_di);
        res_ent.ent = e;
        res_ent.status = rtle_pkg::ST_OK;
    end

    assign same_route = (e.network == r_req.network) && (e.prefix == r_req.prefix);
    assign lpm_hit = (r_dest & mask) == (e.network & mask);
    assign list_hit = ((e.protocol == rtle_pkg::PROTO_CONN) ||
                       (e.protocol == rtle_pkg::PROTO_RIP)) && (e.iface == r_req.iface);
    assign del_hit = (e.protocol == r_req.protocol) &&
                     ((r_cmd == rtle_pkg::CMD_DEL_PI) ? (e.iface == r_req.iface) :
                      (same_route && (e.next_hop == r_req.next_hop)));

    assign list_new = (r_state == S_SCAN) && r_dv && (r_cmd == rtle_pkg::CMD_LIST) &&
                      list_hit && (r_k < KMAX);
    assign stall = list_new && r_pend_v && !i_free;
    assign emit  = list_new && r_pend_v && i_free;

    always_comb begin
        n_state = r_state;  n_cmd = r_cmd;    n_req = r_req;    n_idx = r_idx;
        n_dest = r_dest;    n_count = r_count; n_rd = r_rd;     n_w = r_w;
        n_dv = r_dv;        n_di = r_di;      n_hit = r_hit;    n_best = r_best;
        n_res = r_res;      n_pend = r_pend;  n_pend_v = r_pend_v; n_k = r_k;
        keep = 1'b0;
        o_ram_re = 1'b0;
        o_ram_raddr = r_rd[IW-1:0];
        o_ram_we = 1'b0;
        o_ram_waddr = r_w[IW-1:0];
        o_ram_wdata = e;
        o_msg.valid = 1'b0;
        o_msg.res = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_cmd;
                    n_req = i_req;
                    n_req.prefix = pfx_sat;
                    n_idx = i_entry_index;
                    n_dest = i_dest_addr;
                    n_rd = '0;
                    n_w = '0;
                    n_dv = 1'b0;
                    n_hit = 1'b0;
                    n_best = '0;
                    n_res = res_none;
                    n_pend_v = 1'b0;
                    n_k = '0;
                    n_state = S_SCAN;
                    priority if (i_cmd == rtle_pkg::CMD_DEL_IDX) begin
                        if ({1'b0, i_entry_index} >= 7'(r_count)) begin
                            n_res.status = rtle_pkg::ST_RANGE;
                            n_state = S_FIN;
                        end
                    end else if (i_cmd == rtle_pkg::CMD_CLEAR) begin
                        n_count = '0;
                        n_state = S_FIN;
                    end else if (i_cmd == rtle_pkg::CMD_UNUSED) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (emit) begin
                    o_msg.valid = 1'b1;
                    o_msg.res = r_pend;
                end
                if (!stall) begin
                    if (r_rd < r_count) begin
                        o_ram_re = 1'b1;
                        n_rd = r_rd + 1'b1;
                        n_dv = 1'b1;
                        n_di = r_rd[IW-1:0];
                    end else begin
                        n_dv = 1'b0;
                    end
                    if (r_dv) begin
                        unique case (r_cmd)
                            rtle_pkg::CMD_INSERT: begin
                                if (!r_hit && same_route) begin
                                    if (e.distance > r_req.distance) n_hit = 1'b1;
                                    else n_state = S_FIN;
                                end else begin
                                    keep = 1'b1;
                                end
                            end
                            rtle_pkg::CMD_LOOKUP: begin
                                if (lpm_hit && (!r_hit || (r_best < e.prefix))) begin
                                    n_hit = 1'b1;
                                    n_best = e.prefix;
                                    n_res = res_ent;
                                    n_res.last = 1'b1;
                                end
                            end
                            rtle_pkg::CMD_DEL_IDX: begin
                                if (7'(r_idx) == 7'(r_di)) begin
                                    n_res = res_ent;
                                    n_res.rr = 1'b1;
                                    n_res.last = 1'b1;
                                end else begin
                                    keep = 1'b1;
                                end
                            end
                            rtle_pkg::CMD_DEL_PI, rtle_pkg::CMD_DEL_RT: begin
                                keep = !del_hit;
                            end
                            rtle_pkg::CMD_LIST: begin
                                if (list_new) begin
                                    n_pend = res_ent;
                                    n_pend_v = 1'b1;
                                    n_k = r_k + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (keep) begin
                            // compaction: slide kept entries down over the holes
                            if (r_w != CW'(r_di)) o_ram_we = 1'b1;
                            n_w = r_w + 1'b1;
                        end
                    end else if (r_rd >= r_count) begin
                        n_state = S_FIN;
                        unique case (r_cmd)
                            rtle_pkg::CMD_INSERT: begin
                                o_ram_wdata = r_req;
                                if (r_hit) begin
                                    o_ram_we = 1'b1;
                                    n_count = r_w + 1'b1;
                                end else if (r_count >= DEPTH_C) begin
                                    n_res.status = rtle_pkg::ST_FULL;
                                end else begin
                                    o_ram_we = 1'b1;
                                    o_ram_waddr = r_count[IW-1:0];
                                    n_count = r_count + 1'b1;
                                end
                            end
                            rtle_pkg::CMD_DEL_IDX, rtle_pkg::CMD_DEL_PI,
                            rtle_pkg::CMD_DEL_RT: begin
                                n_count = r_w;
                            end
                            rtle_pkg::CMD_LIST: begin
                                if (r_pend_v) begin
                                    n_res = r_pend;
                                    n_res.last = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_FIN: begin
                o_msg.valid = 1'b1;
                if (i_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_dest <= n_dest;
        r_rd   <= n_rd;
        r_w    <= n_w;
        r_di   <= n_di;
        r_hit  <= n_hit;
        r_best <= n_best;
        r_res  <= n_res;
        r_pend <= n_pend;
        r_k    <= n_k;
    end

endmodule

// File: hw/rtl/route_table_lpm_engine_top.sv
// the engine takes one command at a time
// the scan reads one table entry per cycle through the single ram read port, except while stalled
// list results: one per match, up to MAX_RESULTS; a list scan stalls while the output is held
// reset clears the entry count and control state; table contents are not cleared
// ----------------------------------------------------------------------------
// route_table_lpm_engine_top
// ordered ipv4 route table with longest-prefix-match lookup
// ----------------------------------------------------------------------------
module route_table_lpm_engine_top #(
    parameter int TABLE_DEPTH = rtle_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_network,
    input  logic [5:0]  i_prefix_len,
    input  logic [7:0]  i_distance,
    input  logic [15:0] i_metric,
    input  logic [31:0] i_next_hop,
    input  logic [2:0]  i_protocol,
    input  logic [3:0]  i_interface_req,
    input  logic [5:0]  i_entry_index,
    input  logic [31:0] i_dest_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [5:0]  o_out_index,
    output logic [31:0] o_out_network,
    output logic [5:0]  o_out_prefix,
    output logic [7:0]  o_out_distance,
    output logic [15:0] o_out_metric,
    output logic [31:0] o_out_next_hop,
    output logic [2:0]  o_out_protocol,
    output logic [3:0]  o_out_interface,
    output logic [1:0]  o_status,
    output logic        o_replace_request,
    output logic        o_last
);

    localparam int IW = $clog2(TABLE_DEPTH);

    rtle_pkg::t_entry   req;
    rtle_pkg::t_res_msg msg;
    rtle_pkg::t_result  r_out;
    logic               r_ov;
    logic               free;
    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    rtle_pkg::t_entry   ram_wdata, ram_rdata;

    always_comb begin
        req.network  = i_network;
        req.prefix   = i_prefix_len;
        req.distance = i_distance;
        req.metric   = i_metric;
        req.next_hop = i_next_hop;
        req.protocol = i_protocol;
        req.iface    = i_interface_req;
    end

    assign free = !r_ov || i_out_ready;

    rtle_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_req         (req),
        .i_entry_index (i_entry_index),
        .i_dest_addr   (i_dest_addr),
        .i_free        (free),
        .o_msg         (msg),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

    rtle_ram #(.WIDTH($bits(rtle_pkg::t_entry)), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register, loaded whenever it is empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (msg.valid && free) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (msg.valid && free) begin
            r_out <= msg.res;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_found           = r_out.found;
    assign o_out_index       = r_out.index;
    assign o_out_network     = r_out.ent.network;
    assign o_out_prefix      = r_out.ent.prefix;
    assign o_out_distance    = r_out.ent.distance;
    assign o_out_metric      = r_out.ent.metric;
    assign o_out_next_hop    = r_out.ent.next_hop;
    assign o_out_protocol    = r_out.ent.protocol;
    assign o_out_interface   = r_out.ent.iface;
    assign o_status          = r_out.status;
    assign o_replace_request = r_out.rr;
    assign o_last            = r_out.last;

endmodule

// File: hw/rtl/rtle_checker.sv
// ----------------------------------------------------------------------------
// rtle_checker
// port-level checks of the route table engine, bound to the top level
// ----------------------------------------------------------------------------
`include "route_table_lpm_engine_top_assert.svh"

module rtle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_found,
    input logic [5:0]  o_out_index,
    input logic [31:0] o_out_network,
    input logic [1:0]  o_status,
    input logic        o_replace_request,
    input logic        o_last
);

    // a held result transaction stays valid and keeps its last flag
    `RTLE_AST_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_last))

    // one command in flight: busy right after an accepted transaction
    `RTLE_AST_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // an empty result carries no route
    `RTLE_AST_NOW(a_empty_zero, o_out_valid && !o_found,
                  o_out_index == 6'd0 && o_out_network == 32'd0)

    // replacement request only on a found, single-result delete
    `RTLE_AST_NOW(a_rr_found, o_out_valid && o_replace_request, o_found && o_last)

    // error status never comes with a route
    `RTLE_AST_NOW(a_err_nofound, o_out_valid && o_status != rtle_pkg::ST_OK, !o_found && o_last)

endmodule

bind route_table_lpm_engine_top rtle_checker u_rtle_checker (.*);
